/* sv/assert_macros.svh */
// Assertion macros for the checker file of the comment filter.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define CWF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("comment filter check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define CWF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("comment filter check failed");

`endif

/* sv/cwf_pkg.sv */
// Package of the comment and whitespace filter: character codes and the
// result record passed from the front end through the queue to the back end.
// No dependencies.
package cwf_pkg;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // Most results one input item can cause
  localparam int unsigned MAX_RES = 3;

  // One result: byte and end marker flag
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } slot_t;

  // All results of one item; cnt is 1..MAX_RES for a queued record
  typedef struct packed {
    logic [1:0]          cnt;
    slot_t [MAX_RES-1:0] slot;
  } rec_t;

  // Front end to queue write side
  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

endpackage

/* sv/cwf_front.sv */
// Front end of the comment filter: accepts input transfers, runs the
// comment/whitespace state machine and builds one result record per item.
// Depends on cwf_pkg.
module cwf_front import cwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_at_end,
  input  logic       q_full,
  output push_t      push
);

  typedef enum logic [7:0] {
    MODE_NORMAL    = 8'b0000_0001,
    MODE_SPACE     = 8'b0000_0010,
    MODE_MAYBE_CMT = 8'b0000_0100,
    MODE_LINE_CMT  = 8'b0000_1000,
    MODE_BLOCK_CMT = 8'b0001_0000,
    MODE_MAYBE_END = 8'b0010_0000,
    MODE_MAYBE_ESC = 8'b0100_0000,
    MODE_ENDED     = 8'b1000_0000
  } mode_t;

  mode_t mode_r, mode_nxt;
  rec_t  rec;
  logic  accept;
  logic  blank;

  function automatic slot_t byte_slot(input logic [7:0] b);
    slot_t s;
    s.data = b;
    s.eos  = 1'b0;
    return s;
  endfunction

  function automatic slot_t end_slot();
    slot_t s;
    s.data = 8'h00;
    s.eos  = 1'b1;
    return s;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign blank     = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR) ||
                     (in_byte == CH_VT) || (in_byte == CH_FF);

  // Decode the next mode and the results of this item
  always_comb begin
    mode_nxt = mode_r;
    rec.cnt  = 2'd0;
    rec.slot = '0;
    if (in_at_end) begin
      mode_nxt = MODE_ENDED;
      unique case (mode_r)
        MODE_MAYBE_CMT: begin
          rec.cnt     = 2'd3;
          rec.slot[0] = byte_slot(CH_SLASH);
          rec.slot[1] = byte_slot(CH_NL);
          rec.slot[2] = end_slot();
        end
        MODE_MAYBE_ESC: begin
          rec.cnt     = 2'd3;
          rec.slot[0] = byte_slot(CH_BSLASH);
          rec.slot[1] = byte_slot(CH_NL);
          rec.slot[2] = end_slot();
        end
        MODE_ENDED: begin
          rec.cnt     = 2'd1;
          rec.slot[0] = end_slot();
        end
        default: begin
          rec.cnt     = 2'd2;
          rec.slot[0] = byte_slot(CH_NL);
          rec.slot[1] = end_slot();
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (blank) begin
            mode_nxt = MODE_SPACE;
          end else if (in_byte == CH_SLASH) begin
            mode_nxt = MODE_MAYBE_CMT;
          end else if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_MAYBE_ESC;
          end else begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(in_byte);
          end
        end
        MODE_SPACE: begin
          if (blank) begin
            mode_nxt = MODE_SPACE;
          end else if (in_byte == CH_NL) begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(in_byte);
            mode_nxt    = MODE_NORMAL;
          end else if (in_byte == CH_SLASH) begin
            // drop the pending space ahead of a slash
            mode_nxt = MODE_MAYBE_CMT;
          end else begin
            rec.cnt     = 2'd2;
            rec.slot[0] = byte_slot(CH_SPACE);
            rec.slot[1] = byte_slot(in_byte);
            mode_nxt    = MODE_NORMAL;
          end
        end
        MODE_MAYBE_CMT: begin
          if (blank) begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(CH_SLASH);
            mode_nxt    = MODE_SPACE;
          end else if (in_byte == CH_SLASH) begin
            mode_nxt = MODE_LINE_CMT;
          end else if (in_byte == CH_STAR) begin
            mode_nxt = MODE_BLOCK_CMT;
          end else begin
            rec.cnt     = 2'd2;
            rec.slot[0] = byte_slot(CH_SLASH);
            rec.slot[1] = byte_slot(in_byte);
            mode_nxt    = MODE_NORMAL;
          end
        end
        MODE_LINE_CMT: begin
          if (in_byte == CH_NL) begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(in_byte);
            mode_nxt    = MODE_NORMAL;
          end
        end
        MODE_BLOCK_CMT: begin
          if (in_byte == CH_STAR) begin
            mode_nxt = MODE_MAYBE_END;
          end
        end
        MODE_MAYBE_END: begin
          if (in_byte == CH_SLASH) begin
            mode_nxt = MODE_SPACE;
          end else if (in_byte != CH_STAR) begin
            mode_nxt = MODE_BLOCK_CMT;
          end
        end
        MODE_MAYBE_ESC: begin
          if (in_byte == CH_NL) begin
            // line continuation: drop backslash and newline
            mode_nxt = MODE_SPACE;
          end else if (blank) begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(CH_BSLASH);
            mode_nxt    = MODE_SPACE;
          end else if (in_byte == CH_SLASH) begin
            rec.cnt     = 2'd1;
            rec.slot[0] = byte_slot(CH_BSLASH);
            mode_nxt    = MODE_MAYBE_CMT;
          end else begin
            rec.cnt     = 2'd2;
            rec.slot[0] = byte_slot(CH_BSLASH);
            rec.slot[1] = byte_slot(in_byte);
            mode_nxt    = MODE_NORMAL;
          end
        end
        MODE_ENDED: begin
          // pass bytes through once the stream has ended
          rec.cnt     = 2'd1;
          rec.slot[0] = byte_slot(in_byte);
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end
  end

  // Push only items that produce results
  assign push.valid = accept && (rec.cnt != 2'd0);
  assign push.rec   = rec;

  // Advance the mode on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

/* sv/cwf_queue.sv */
// Short record queue between front and back end of the comment filter.
// Register array with read and write pointers. Depends on cwf_pkg.
module cwf_queue import cwf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output rec_t  rd_rec,
  output logic  empty,
  output logic  full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload without reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

endmodule

/* sv/cwf_back.sv */
// Back end of the comment filter: takes records from the queue and sends
// their results one transfer at a time, marking the last. Depends on cwf_pkg.
module cwf_back import cwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  rec_t       q_rec,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_end,
  output logic       out_last
);

  rec_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  slot_t      sel;
  logic       last;
  logic       done;

  assign sel  = cur_r.slot[idx_r];
  assign last = (idx_r == cur_r.cnt - 2'd1);
  assign done = cur_valid_r && out_tready && last;
  assign pop  = !q_empty && (!cur_valid_r || done);

  assign out_tvalid = cur_valid_r;
  assign out_byte   = sel.data;
  assign out_end    = sel.eos;
  assign out_last   = last;

  // Load the next record or step to the next result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (cur_valid_r && out_tready) begin
      if (last) begin
        cur_valid_r <= 1'b0;
        idx_r       <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Hold the record payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_rec;
    end
  end

endmodule

/* sv/comment_whitespace_filter_core.sv */
// Top level of the comment and whitespace filter.
// Instantiates cwf_front, cwf_queue and cwf_back; depends on cwf_pkg.
//
// The filter takes one source byte, or an end marker flagged on in_tuser,
// per input transfer, strips // and /* */ comments, collapses whitespace
// runs to one space, drops backslash-newline pairs and ends the stream
// with a newline and an end marker (flagged on out_tuser). Each input item
// gives zero to three results; out_tlast marks the last result of an item.
// An input transfer is taken every cycle while the record queue has room;
// the output sends one result per cycle while out_tready is high, and the
// queue of QUEUE_DEPTH records absorbs the bursts of items with several
// results. An item is first written into the queue, then loaded from it
// into the back end's record register, which drives out_tvalid for its
// first result. No clearing pass follows reset.
module comment_whitespace_filter_core import cwf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] at_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] out_end
  output logic       out_tlast
);

  push_t push;
  rec_t  q_rec;
  logic  q_full, q_empty, pop;

  cwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_at_end (in_tuser),
    .q_full    (q_full),
    .push      (push)
  );

  cwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .rd_rec (q_rec),
    .empty  (q_empty),
    .full   (q_full)
  );

  cwf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rec      (q_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_end    (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

/* sv/cwf_checker.sv */
// Port-level checks for comment_whitespace_filter_core, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cwf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // End marker always closes the run of its item
  `CWF_ASSERT_IMP(a_end_is_last, out_tvalid && out_tuser, out_tlast)
  // End marker carries a zero byte
  `CWF_ASSERT_IMP(a_end_zero, out_tvalid && out_tuser, out_tdata == 8'h00)
  // Results of one item follow without a gap
  `CWF_ASSERT_NXT(a_run_no_gap, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // Stalled result stays offered
  `CWF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

endmodule

bind comment_whitespace_filter_core cwf_checker u_cwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* bench/comment_whitespace_filter_core_test.sv */
// Self-checking bench for comment_whitespace_filter_core: feeds source bytes and end markers,
// predicts the filtered stream and compares every output transfer field by field.
// Depends on cwf_pkg and the RTL of the filter only.
module comment_whitespace_filter_core_test;
  import cwf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  // Filter modes of the model, one for each mode of the block
  typedef enum logic [2:0] {
    ST_TEXT, ST_SPACE, ST_SLASH, ST_LINE, ST_BLOCK, ST_STAR, ST_BSLASH, ST_DONE
  } strip_mode_t;

  // One filtered output byte as expected on the output
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       last;
  } strip_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tuser = 1'b0;    // [0] at_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tuser;          // [0] out_end
  logic       out_tlast;

  strip_mode_t mode_model = ST_TEXT;
  strip_res_t  filtered_q[$];
  bit          feed_calm = 1'b1;
  bit          drain_calm = 1'b1;
  int          items_fed = 0;
  int          ends_fed = 0;
  int          bytes_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  string       end_mode_name = "none";

  comment_whitespace_filter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, filtered_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
  endfunction

  function automatic strip_res_t as_char(logic [7:0] c);
    return '{c, 1'b0, 1'b0};
  endfunction

  // Advance the mode model by one input item and queue the bytes it yields
  function automatic void predict_item(logic [7:0] c, logic e);
    strip_res_t  res[$];
    strip_mode_t nxt;
    nxt = mode_model;
    if (e) begin
      if (mode_model == ST_SLASH) res.push_back(as_char(CH_SLASH));
      else if (mode_model == ST_BSLASH) res.push_back(as_char(CH_BSLASH));
      if (mode_model != ST_DONE) res.push_back(as_char(CH_NL));
      res.push_back('{8'h00, 1'b1, 1'b0});
      nxt = ST_DONE;
    end else begin
      case (mode_model)
        ST_TEXT: begin
          if (is_blank(c)) nxt = ST_SPACE;
          else if (c == CH_SLASH) nxt = ST_SLASH;
          else if (c == CH_BSLASH) nxt = ST_BSLASH;
          else res.push_back(as_char(c));
        end
        ST_SPACE: begin
          if (is_blank(c)) begin
            // collapse into the pending space
          end else if (c == CH_NL) begin
            res.push_back(as_char(c));
            nxt = ST_TEXT;
          end else if (c == CH_SLASH) begin
            nxt = ST_SLASH;
          end else begin
            res.push_back(as_char(CH_SPACE));
            res.push_back(as_char(c));
            nxt = ST_TEXT;
          end
        end
        ST_SLASH: begin
          if (is_blank(c)) begin
            res.push_back(as_char(CH_SLASH));
            nxt = ST_SPACE;
          end else if (c == CH_SLASH) begin
            nxt = ST_LINE;
          end else if (c == CH_STAR) begin
            nxt = ST_BLOCK;
          end else begin
            res.push_back(as_char(CH_SLASH));
            res.push_back(as_char(c));
            nxt = ST_TEXT;
          end
        end
        ST_LINE: begin
          if (c == CH_NL) begin
            res.push_back(as_char(c));
            nxt = ST_TEXT;
          end
        end
        ST_BLOCK: begin
          if (c == CH_STAR) nxt = ST_STAR;
        end
        ST_STAR: begin
          if (c == CH_SLASH) nxt = ST_SPACE;
          else if (c != CH_STAR) nxt = ST_BLOCK;
        end
        ST_BSLASH: begin
          if (c == CH_NL) begin
            nxt = ST_SPACE;
          end else if (is_blank(c)) begin
            res.push_back(as_char(CH_BSLASH));
            nxt = ST_SPACE;
          end else if (c == CH_SLASH) begin
            res.push_back(as_char(CH_BSLASH));
            nxt = ST_SLASH;
          end else begin
            res.push_back(as_char(CH_BSLASH));
            res.push_back(as_char(c));
            nxt = ST_TEXT;
          end
        end
        default: res.push_back(as_char(c));
      endcase
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) filtered_q.push_back(res[i]);
    mode_model = nxt;
  endfunction

  // Send one item, wait for its transfer and predict its output
  task automatic feed_item(input logic [7:0] b, input logic e);
    int gap;
    gap = feed_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(b, e);
    items_fed++;
    if (e) ends_fed++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Draw a byte of ordinary text class
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = any_byte();
    while (is_blank(c) || c == CH_NL || c == CH_SLASH || c == CH_BSLASH || c == CH_STAR);
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic void report(string what, int exp_val, int got_val);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
    mismatches++;
  endfunction

  // Drain the output with random stalls and check each transfer
  initial begin : drain
    int         hold;
    strip_res_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = drain_calm ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      bytes_checked++;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got byte %0h end %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== want.ch) report("out_byte", want.ch, out_tdata);
        if (out_tuser !== want.eos) report("out_end", want.eos, out_tuser);
        if (out_tlast !== want.last) report("last_of_run", want.last, out_tlast);
      end
    end
  end

  // Ordinary bytes at the extremes of the code range
  task automatic test_text_bytes();
    feed_calm = 1'b1;
    drain_calm = 1'b1;
    feed_item(8'h00, 1'b0);
    feed_item(8'hFF, 1'b0);
  endtask

  // Every blank kind collapses to one space; a blank run before a newline vanishes
  task automatic test_whitespace();
    drain_calm = 1'b0;
    feed_item(CH_SPACE, 1'b0);
    feed_item(CH_TAB, 1'b0);
    feed_item(CH_CR, 1'b0);
    feed_item(CH_VT, 1'b0);
    feed_item(CH_FF, 1'b0);
    feed_text("a");
    feed_item(CH_SPACE, 1'b0);
    feed_item(CH_NL, 1'b0);
  endtask

  // Space dropped before a slash, line comment, block comment with a star run, stray slash
  task automatic test_comments();
    feed_calm = 1'b0;
    feed_text(" //\n/***//z");
  endtask

  // Backslash-newline dropped, backslash after a space passed as is, stray backslashes
  task automatic test_escapes();
    drain_calm = 1'b1;
    feed_text("\\\n\\\\\\/x\\ y");
  endtask

  // Send one well-formed token with random content, or a broken one, or noise
  task automatic feed_random_token();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 8);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: repeat (n + 1) feed_item(plain_byte(), 1'b0);
      6, 7, 8: begin
        repeat (n / 2 + 1) feed_item(pick_blank(), 1'b0);
        if ($urandom_range(0, 2) == 0) feed_item(CH_NL, 1'b0);
      end
      9: feed_item(CH_NL, 1'b0);
      10, 11: begin
        feed_text("//");
        repeat (n) begin
          do c = any_byte(); while (c == CH_NL);
          feed_item(c, 1'b0);
        end
        feed_item(CH_NL, 1'b0);
      end
      12, 13: begin
        feed_text("/*");
        repeat (n) feed_item(($urandom_range(0, 3) == 0) ? CH_STAR : any_byte(), 1'b0);
        feed_text("*/");
      end
      14: feed_text("\\\n");
      15: begin
        feed_item($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH, 1'b0);
        feed_item(any_byte(), 1'b0);
      end
      16: begin
        // broken sequences: half comment openers and closers
        case ($urandom_range(0, 2))
          0: feed_item(CH_SLASH, 1'b0);
          1: feed_text("\\/");
          default: feed_text("*/");
        endcase
        feed_item(pick_blank(), 1'b0);
      end
      default: repeat (n / 2 + 1) feed_item(any_byte(), 1'b0);
    endcase
  endtask

  // Random source text; toggle calm stretches on both sides now and then
  task automatic test_random_source();
    int start;
    start = items_fed;
    while (items_fed - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) feed_calm = !feed_calm;
      if ($urandom_range(0, 7) == 0) drain_calm = !drain_calm;
      feed_random_token();
    end
  endtask

  // Bring the filter to a random mode, end the stream, then send items after the end
  task automatic test_end_of_stream();
    strip_mode_t target;
    int          n;
    target = strip_mode_t'($urandom_range(0, 6));
    // this sequence returns to normal text from any mode but the ended one
    feed_text("\n*/\nx");
    case (target)
      ST_SPACE:  feed_item(pick_blank(), 1'b0);
      ST_SLASH:  feed_item(CH_SLASH, 1'b0);
      ST_LINE:   feed_text("//q");
      ST_BLOCK:  feed_text("/*q");
      ST_STAR:   feed_text("/*q*");
      ST_BSLASH: feed_item(CH_BSLASH, 1'b0);
      default: ;
    endcase
    end_mode_name = mode_model.name();
    feed_item(any_byte(), 1'b1);
    n = $urandom_range(3, 8);
    repeat (n) feed_item(any_byte(), 1'($urandom_range(0, 1)));
    feed_item(any_byte(), 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_text_bytes();
    test_whitespace();
    test_comments();
    test_escapes();
    test_random_source();
    test_end_of_stream();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("fed %0d items (%0d end markers), checked %0d output transfers",
             items_fed, ends_fed, bytes_checked);
    $display("stream ended from mode %s, with items after the end", end_mode_name);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
